>>> rtl/dta_pkg.sv
// ============================================================================
// dta_pkg - shared definitions of the descriptor table allocator
// Field widths, operation and status codes, and parameter defaults.
// ============================================================================
package dta_pkg;

	// Field widths of the request and response words.
	localparam int OPCODE_W = 2;
	localparam int DESC_W   = 6;
	localparam int HANDLE_W = 16;
	localparam int PERM_W   = 2;
	localparam int STATUS_W = 2;

	// Parameter defaults of the top level.
	localparam int MAX_DESC_DEF    = 64;
	localparam int HANDLE_BITS_DEF = 16;

	// Width of one row of the used bitmap memory.
	localparam int ROW_W   = 32;
	localparam int ROW_IDX = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSTALL = 2'd0,
		OP_GET     = 2'd1,
		OP_CLOSE   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_BADF  = 2'd1,
		STAT_MFILE = 2'd2
	} status_t;

endpackage

>>> rtl/dta_req_if.sv
// ============================================================================
// dta_req_if - request channel of the descriptor table allocator
// Carries one operation word with a valid/ready handshake.
// ============================================================================
interface dta_req_if
	import dta_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DESC_W-1:0]   desc_number;
	logic [HANDLE_W-1:0] object_handle;
	logic [PERM_W-1:0]   object_perms;
	logic [PERM_W-1:0]   wanted_perms;

	modport source (
		output valid, opcode, desc_number, object_handle, object_perms, wanted_perms,
		input  ready
	);
	modport sink (
		input  valid, opcode, desc_number, object_handle, object_perms, wanted_perms,
		output ready
	);
endinterface

>>> rtl/dta_rsp_if.sv
// ============================================================================
// dta_rsp_if - response channel of the descriptor table allocator
// Carries one result word with a valid/ready handshake.
// ============================================================================
interface dta_rsp_if
	import dta_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DESC_W-1:0]   desc_out;
	logic [HANDLE_W-1:0] handle_out;

	modport source (
		output valid, status, desc_out, handle_out,
		input  ready
	);
	modport sink (
		input  valid, status, desc_out, handle_out,
		output ready
	);
endinterface

>>> rtl/descriptor_table_allocator_core.sv
// ============================================================================
// descriptor_table_allocator_core - lowest-free descriptor table
// Install, get and close of object handles over a bitmap and an entry store.
// ============================================================================
//
//  channel  dir  handshake     word contents
//  -------  ---  ------------  ------------------------------------------------
//  req      in   valid/ready   opcode, desc_number, object_handle, perms
//  rsp      out  valid/ready   status, desc_out, handle_out
//
// Every operation has two steps: the accept cycle selects a bitmap row
// and issues reads of the bitmap memory and the entry memory, and the
// execute cycle decides, writes back and loads the response register.
// The split is set by the registered reads of the memories
// and by the read-modify-write of the bitmap row, which must finish before
// the next operation reads the table.
// Reset clears the row-full and row-valid flags at once; a bitmap row that
// has never been written reads as empty, so no clearing pass is needed.
// A stalled response holds the block in its execute cycle; no new request
// is taken until the pending word has been moved into the response register.
//
module descriptor_table_allocator_core
	import dta_pkg::*;
#(
	parameter int MAX_DESC    = MAX_DESC_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	dta_req_if.sink   req,
	dta_rsp_if.source rsp
);

	// Stored handle width: the handle port is 16 bits wide, so a wider
	// setting stores no more than that.
	localparam int HW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int EW   = HW + PERM_W;
	localparam int IW   = $clog2(MAX_DESC);
	localparam int ROWS = (MAX_DESC + ROW_W - 1) / ROW_W;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW   = RW + ROW_IDX;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// Per-row flags in flip-flops: the row holds written data, and the row
	// has no free slot left.
	logic [ROWS-1:0] row_valid_q;
	logic [ROWS-1:0] row_full_q;

	// Bitmap memory, one row of slots per entry.
	logic [ROW_W-1:0] bm_mem [ROWS];
	logic [ROW_W-1:0] bm_rd_q;

	// Operation registers of the execute cycle.
	op_t                 op_s1;
	logic [RW-1:0]       row_s1;
	logic [ROW_IDX-1:0]  bit_s1;
	logic [HW-1:0]       hnd_s1;
	logic [PERM_W-1:0]   operm_s1;
	logic [PERM_W-1:0]   wperm_s1;
	logic                inrange_s1;
	logic                anyfree_s1;

	// Response register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DESC_W-1:0]   desc_q;
	logic [HANDLE_W-1:0] handle_q;

	// Marks slots past the end of the table as permanently used.
	function automatic logic [ROW_W-1:0] pad_bits(input logic [RW-1:0] r);
		logic [ROW_W-1:0] p;
		int               g;
		p = '0;
		for (int b = 0; b < ROW_W; b++) begin
			g    = int'(r) * ROW_W + b;
			p[b] = (g >= MAX_DESC);
		end
		return p;
	endfunction

	// Index of the lowest clear bit of a row.
	function automatic logic [ROW_IDX-1:0] lowest_zero(input logic [ROW_W-1:0] v);
		logic [ROW_IDX-1:0] idx;
		idx = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (!v[b]) begin
				idx = ROW_IDX'(b);
			end
		end
		return idx;
	endfunction

	// ------------------------------------------------------------------
	// Accept cycle: pick the row and issue the memory reads.
	// ------------------------------------------------------------------
	logic              accept;
	logic              in_range;
	logic [SW-1:0]     d_slot;
	logic [RW-1:0]     free_row;
	logic              any_free;
	logic [RW-1:0]     rd_row;
	logic [IW-1:0]     rd_idx;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = (32'(req.desc_number) < MAX_DESC);
	assign d_slot    = in_range ? SW'(req.desc_number) : '0;
	assign any_free  = !(&row_full_q);

	always_comb begin
		free_row = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				free_row = RW'(r);
			end
		end
	end

	assign rd_row = (op_t'(req.opcode) == OP_INSTALL) ? free_row : d_slot[SW-1:ROW_IDX];
	assign rd_idx = d_slot[IW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			bm_rd_q    <= bm_mem[rd_row];
			op_s1      <= op_t'(req.opcode);
			row_s1     <= rd_row;
			bit_s1     <= d_slot[ROW_IDX-1:0];
			hnd_s1     <= req.object_handle[HW-1:0];
			operm_s1   <= req.object_perms;
			wperm_s1   <= req.wanted_perms;
			inrange_s1 <= in_range;
			anyfree_s1 <= any_free;
		end
	end

	// ------------------------------------------------------------------
	// Execute cycle: decide, write back and build the response.
	// ------------------------------------------------------------------
	logic                fire;
	logic [ROW_W-1:0]    row_eff;
	logic [ROW_IDX-1:0]  free_bit;
	logic [SW-1:0]       new_slot;
	logic [EW-1:0]       ent_rd;
	logic [PERM_W-1:0]   perm_rd;
	logic [HW-1:0]       hnd_rd;
	logic                used_bit;

	logic                bm_we;
	logic [ROW_W-1:0]    bm_wdata;
	logic                ent_we;
	logic [STATUS_W-1:0] status_d;
	logic [DESC_W-1:0]   desc_d;
	logic [HANDLE_W-1:0] handle_d;

	assign fire     = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);
	assign row_eff  = row_valid_q[row_s1] ? (bm_rd_q | pad_bits(row_s1)) : pad_bits(row_s1);
	assign free_bit = lowest_zero(row_eff);
	assign new_slot = {row_s1, free_bit};
	assign perm_rd  = ent_rd[EW-1:HW];
	assign hnd_rd   = ent_rd[HW-1:0];
	assign used_bit = inrange_s1 && row_eff[bit_s1];

	always_comb begin
		bm_we    = 1'b0;
		bm_wdata = row_eff;
		ent_we   = 1'b0;
		status_d = STAT_BADF;
		desc_d   = '0;
		handle_d = '0;
		case (op_s1)
			OP_INSTALL: begin
				if (anyfree_s1) begin
					status_d = STAT_OK;
					desc_d   = new_slot[DESC_W-1:0];
					bm_we    = 1'b1;
					bm_wdata = row_eff | (ROW_W'(1) << free_bit);
					ent_we   = 1'b1;
				end else begin
					status_d = STAT_MFILE;
				end
			end
			OP_GET: begin
				if (used_bit && ((wperm_s1 & ~perm_rd) == '0)) begin
					status_d = STAT_OK;
					handle_d = HANDLE_W'(hnd_rd);
				end
			end
			OP_CLOSE: begin
				if (used_bit) begin
					status_d = STAT_OK;
					handle_d = HANDLE_W'(hnd_rd);
					bm_we    = 1'b1;
					bm_wdata = row_eff & ~(ROW_W'(1) << bit_s1);
				end
			end
			default: begin
				status_d = STAT_BADF;
			end
		endcase
	end

	// The entry store is written only by install, and its data is used only
	// while the slot is in use, so close leaves it as it is.
	dta_entry_ram #(
		.DEPTH  (MAX_DESC),
		.DATA_W (EW)
	) u_entry_ram (
		.clk   (clk),
		.we    (fire && ent_we),
		.waddr (new_slot[IW-1:0]),
		.wdata ({operm_s1, hnd_s1}),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (ent_rd)
	);

	always_ff @(posedge clk) begin
		if (fire && bm_we) begin
			bm_mem[row_s1] <= bm_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			row_full_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fire && bm_we) begin
				row_valid_q[row_s1] <= 1'b1;
				row_full_q[row_s1]  <= &bm_wdata;
			end

			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			desc_q   <= desc_d;
			handle_q <= handle_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.desc_out   = desc_q;
	assign rsp.handle_out = handle_q;

endmodule

>>> rtl/dta_entry_ram.sv
// ============================================================================
// dta_entry_ram - entry store of the descriptor table
// Simple dual-port memory, one write and one registered read per cycle.
// ============================================================================
module dta_entry_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 18,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
